// ===== sv/wgm_pkg.sv =====
// ----------------------------------------------------------------------------
// wgm_pkg: shared types and constants of the wildcard glob matcher
// Beat payloads, cell links, register map and pattern sizing.
// ----------------------------------------------------------------------------
package wgm_pkg;

   // pattern sizing
   localparam int PATTERN_MAX = 32;
   localparam int PAT_BYTES   = 32;
   localparam int PAT_WORDS   = 4;
   localparam int LEN_W       = 6;
   localparam int LEN_LIMIT   = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
   localparam int COL_IDX_W   = $clog2(PATTERN_MAX + 1);

   // register port
   localparam int DATA_W    = 64;
   localparam int ADDR_W    = 6;
   localparam int REG_IDX_W = 3;

   localparam logic [REG_IDX_W-1:0] REG_PAT_WORD_0 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PAT_WORD_1 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_PAT_WORD_2 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_PAT_WORD_3 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_PAT_LEN    = 3'd4;

   // wildcard bytes
   localparam logic [7:0] STAR_CHAR = 8'h2A;
   localparam logic [7:0] ANY_CHAR  = 8'h3F;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       text_end;
      logic       empty_text;
   } wgm_req_type;

   typedef struct packed {
      logic matched;
      logic text_done;
   } wgm_rsp_type;

   // configuration as seen by the cell row
   typedef struct packed {
      logic [PAT_BYTES-1:0][7:0] pattern;
      logic [COL_IDX_W-1:0]      used_len;
   } wgm_cfg_type;

   // shared by every cell in a cycle
   typedef struct packed {
      logic [7:0] text_byte;
      logic       at_start;
      logic       step;
   } wgm_bcast_type;

   // handed from one cell to its right neighbor
   typedef struct packed {
      logic eff;
      logic fresh;
      logic star_run;
   } wgm_link_type;

endpackage

// ===== sv/wgm_cell.sv =====
// ----------------------------------------------------------------------------
// wgm_cell: one pattern position of the match column
// Holds one column bit and computes its next value from its left neighbor.
// ----------------------------------------------------------------------------
module wgm_cell (
   input  logic                 clock,
   input  logic [7:0]           pat_byte,
   input  logic                 enable,
   input  wgm_pkg::wgm_bcast_type bcast,
   input  wgm_pkg::wgm_link_type  left,
   output wgm_pkg::wgm_link_type  right
);
   import wgm_pkg::*;

   logic col_ff;
   logic col_in;
   logic is_star;
   logic is_hit;
   logic star_run;
   logic eff;
   logic fresh;

   always_comb begin
      is_star  = (pat_byte == STAR_CHAR);
      is_hit   = (pat_byte == bcast.text_byte) || (pat_byte == ANY_CHAR);
      star_run = left.star_run & enable & is_star;
      // at text start the column is the all-star prefix
      eff      = bcast.at_start ? star_run : col_ff;
      if (!enable) begin
         fresh = 1'b0;
      end else if (is_hit) begin
         fresh = left.eff;
      end else if (is_star) begin
         fresh = left.fresh | eff;
      end else begin
         fresh = 1'b0;
      end
      col_in         = bcast.step ? fresh : col_ff;
      right.eff      = eff;
      right.fresh    = fresh;
      right.star_run = star_run;
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
   end

endmodule

// ===== sv/wgm_csr.sv =====
// ----------------------------------------------------------------------------
// wgm_csr: pattern and length registers
// APB-style write/read access; hands the pattern and clamped length to the row.
// ----------------------------------------------------------------------------
module wgm_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [wgm_pkg::ADDR_W-1:0] paddr,
   input  logic [wgm_pkg::DATA_W-1:0] pwdata,
   output logic [wgm_pkg::DATA_W-1:0] prdata,
   output logic                       pready,
   output wgm_pkg::wgm_cfg_type       cfg
);
   import wgm_pkg::*;

   logic [DATA_W-1:0]    pat_word_ff [PAT_WORDS];
   logic [DATA_W-1:0]    pat_word_in [PAT_WORDS];
   logic [LEN_W-1:0]     len_ff;
   logic [LEN_W-1:0]     len_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[ADDR_W-1:3];
   assign wr_en   = psel & penable & pwrite;

   always_comb begin
      for (int w = 0; w < PAT_WORDS; w++) begin
         pat_word_in[w] = pat_word_ff[w];
      end
      len_in = len_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PAT_WORD_0: pat_word_in[0] = pwdata;
            REG_PAT_WORD_1: pat_word_in[1] = pwdata;
            REG_PAT_WORD_2: pat_word_in[2] = pwdata;
            REG_PAT_WORD_3: pat_word_in[3] = pwdata;
            REG_PAT_LEN:    len_in = pwdata[LEN_W-1:0];
            default:        len_in = len_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < PAT_WORDS; w++) begin
            pat_word_ff[w] <= '0;
         end
         len_ff <= '0;
      end else begin
         for (int w = 0; w < PAT_WORDS; w++) begin
            pat_word_ff[w] <= pat_word_in[w];
         end
         len_ff <= len_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PAT_WORD_0: prdata = pat_word_ff[0];
         REG_PAT_WORD_1: prdata = pat_word_ff[1];
         REG_PAT_WORD_2: prdata = pat_word_ff[2];
         REG_PAT_WORD_3: prdata = pat_word_ff[3];
         REG_PAT_LEN:    prdata = {{(DATA_W-LEN_W){1'b0}}, len_ff};
         default:        prdata = '0;
      endcase
   end

   always_comb begin
      for (int w = 0; w < PAT_WORDS; w++) begin
         for (int b = 0; b < 8; b++) begin
            cfg.pattern[8*w+b] = pat_word_ff[w][8*b +: 8];
         end
      end
      // clamp to what the registers and the row can hold
      if (len_ff > LEN_W'(LEN_LIMIT)) begin
         cfg.used_len = COL_IDX_W'(LEN_LIMIT);
      end else begin
         cfg.used_len = COL_IDX_W'(len_ff);
      end
   end

endmodule

// ===== sv/wgm_rsp_buf.sv =====
// ----------------------------------------------------------------------------
// wgm_rsp_buf: two-entry result buffer
// Head register plus skid slot; push side ready comes straight from a flop.
// ----------------------------------------------------------------------------
module wgm_rsp_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  wgm_pkg::wgm_rsp_type push_data,
   output logic                 push_ready,
   output logic                 pop_valid,
   output wgm_pkg::wgm_rsp_type pop_data,
   input  logic                 pop_ready
);
   import wgm_pkg::*;

   logic        head_valid_ff;
   logic        head_valid_in;
   wgm_rsp_type head_ff;
   wgm_rsp_type head_in;
   logic        skid_valid_ff;
   logic        skid_valid_in;
   wgm_rsp_type skid_ff;
   wgm_rsp_type skid_in;
   logic        pop;

   assign push_ready = ~skid_valid_ff;
   assign pop_valid  = head_valid_ff;
   assign pop_data   = head_ff;
   assign pop        = head_valid_ff & pop_ready;

   always_comb begin
      head_valid_in = head_valid_ff;
      head_in       = head_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!head_valid_ff) begin
         head_valid_in = push_valid;
         head_in       = push_data;
      end else if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_valid_in = push_valid;
            head_in       = push_data;
         end
      end else if (push_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTHESIS
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid slot full while head empty");

   a_head_held: assert property (@(posedge clock) disable iff (reset)
      head_valid_ff && !pop_ready |=> head_valid_ff && $stable(head_ff))
      else $error("stalled result lost or changed");
`endif

endmodule

// ===== sv/wildcard_glob_matcher_top.sv =====
// ----------------------------------------------------------------------------
// Results: a result beat is registered in the result buffer before rsp.
// Throughput: one text byte per cycle while the skid slot is free; the clock
//   period is set by the ripple of the star/diagonal chain through all cells.
// Reset: synchronous; clears CSRs and valid flags; column reloads next text.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_top (
   input  logic                       clock,
   input  logic                       reset,
   // text byte beats
   input  logic                       req_valid,
   output logic                       req_ready,
   input  wgm_pkg::wgm_req_type       req_data,
   // result beats
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output wgm_pkg::wgm_rsp_type       rsp_data,
   // register port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [wgm_pkg::ADDR_W-1:0] paddr,
   input  logic [wgm_pkg::DATA_W-1:0] pwdata,
   output logic [wgm_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import wgm_pkg::*;

   // Structure: a row of PATTERN_MAX cells, cell i owning column bit i
   // (text so far matches pattern bytes 0..i-1). Bit 0 is implicit: it is
   // 1 only at text start. Each cycle the row passes three bits rightward:
   //   eff      - the cell's old bit (star prefix when a text starts)
   //   fresh    - the cell's new bit, feeding a '*' to its right
   //   star_run - all pattern bytes so far are '*'
   // The answer is tapped at position used_len from eff (empty text) or
   // fresh (normal byte), then queued in a two-entry buffer so the row
   // keeps taking beats while a result waits.

   wgm_cfg_type          cfg;
   wgm_bcast_type        bcast;
   wgm_link_type         link [PATTERN_MAX+1];
   logic [PATTERN_MAX:0] eff_vec;
   logic [PATTERN_MAX:0] fresh_vec;
   logic [PATTERN_MAX:1] enable_vec;
   logic                 at_start_ff;
   logic                 at_start_in;
   logic                 accept;
   wgm_rsp_type          result;

   wgm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign accept = req_valid & req_ready;

   // broadcast to all cells; an empty text leaves the column untouched
   assign bcast.text_byte = req_data.text_byte;
   assign bcast.at_start  = at_start_ff;
   assign bcast.step      = accept & ~req_data.empty_text;

   // left edge of the row: implicit bit 0
   assign link[0].eff      = at_start_ff;
   assign link[0].fresh    = 1'b0;
   assign link[0].star_run = 1'b1;

   generate
      for (genvar k = 1; k <= PATTERN_MAX; k++) begin : g_cell
         logic [7:0] pat_byte;
         if (k - 1 < PAT_BYTES) begin : g_byte
            assign pat_byte = cfg.pattern[k-1];
         end else begin : g_none
            assign pat_byte = 8'h00;
         end
         // cells past the pattern length hold zero
         assign enable_vec[k] = (COL_IDX_W'(k) <= cfg.used_len);

         wgm_cell u_cell (
            .clock    (clock),
            .pat_byte (pat_byte),
            .enable   (enable_vec[k]),
            .bcast    (bcast),
            .left     (link[k-1]),
            .right    (link[k])
         );
      end
   endgenerate

   always_comb begin
      for (int k = 0; k <= PATTERN_MAX; k++) begin
         eff_vec[k]   = link[k].eff;
         fresh_vec[k] = link[k].fresh;
      end
   end

   // result tap and text-start tracking
   always_comb begin
      result.matched   = req_data.empty_text ? eff_vec[cfg.used_len]
                                             : fresh_vec[cfg.used_len];
      result.text_done = req_data.empty_text | req_data.text_end;
      at_start_in      = accept ? result.text_done : at_start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
      end else begin
         at_start_ff <= at_start_in;
      end
   end

   wgm_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (accept),
      .push_data  (result),
      .push_ready (req_ready),
      .pop_valid  (rsp_valid),
      .pop_data   (rsp_data),
      .pop_ready  (rsp_ready)
   );

`ifndef SYNTHESIS
   a_empty_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.empty_text |=> at_start_ff)
      else $error("empty text did not return to text start");

   a_mid_text: assert property (@(posedge clock) disable iff (reset)
      accept && !req_data.empty_text && !req_data.text_end |=> !at_start_ff)
      else $error("text start flagged inside a text");

   a_result_queued: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted beat produced no result");
`endif

endmodule
